### rtl/core/gsp_pkg.sv
`default_nettype none
package gsp_pkg;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_GRID_WIDTH  = 3'd1,
        REG_GRID_HEIGHT = 3'd2,
        REG_GAIN_ROWS   = 3'd3,
        REG_GAIN_COLS   = 3'd4,
        REG_DAMPING     = 3'd5,
        REG_STEP_DT     = 3'd6
    } reg_index_t;

    localparam logic        MODE_HEAT = 1'b0;
    localparam logic        MODE_WAVE = 1'b1;

    localparam logic [8:0]  RST_GRID_WIDTH  = 9'd200;
    localparam logic [8:0]  RST_GRID_HEIGHT = 9'd200;
    localparam logic [30:0] RST_GAIN_ROWS   = 31'd10630366;
    localparam logic [30:0] RST_GAIN_COLS   = 31'd10630366;
    localparam logic [31:0] RST_DAMPING     = 32'd2147268900;
    localparam logic [31:0] RST_STEP_DT     = 32'd4294967;

    typedef struct packed {
        logic        mode;
        logic [8:0]  grid_width;
        logic [8:0]  grid_height;
        logic [30:0] gain_rows;
        logic [30:0] gain_cols;
        logic [31:0] damping;
        logic [31:0] step_dt;
    } cfg_t;

    // One classified cell on its way from the front to the back.
    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [7:0]         emit_row;
        logic [7:0]         row;
        logic [7:0]         col;
        logic               emit;
        logic               border;
        logic               last_row;
        logic               last_col;
    } cell_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/grid_stencil_pde_step.sv
// One explicit step of a five-point finite-difference stencil over a grid.
// Input channel s_*: one cell per transaction in raster order, tdata holds
// cell_value and cell_velocity. Output channel m_*: each cell once, tdata holds
// out_row, out_col, new_value, new_velocity; tlast marks the last cell of a pass.
// Row 0 gives no result, middle rows give the cell above, the last row gives
// the cell above and then the arriving cell. Border cells pass unchanged.
// Border and non-emitted cells skip the arithmetic in the back sequencer. An
// interior cell scales the row and column differences, and in wave mode also
// the damping and time step, each term as two 34x16 partial products on shared
// operands, and each line store has a single read port. A two-entry
// queue lets the front take the next cell while the back works, and an output
// register holds a finished result while the receiver stalls; the back waits
// on that register, the front only on a full queue. Reset (aresetn low, sync)
// clears the counters, queue, sequencer and output valid, and loads the
// register defaults. The line stores are not cleared. The user, not the block,
// must write configuration through cfg_we/cfg_index/cfg_data while the block is idle.
`default_nettype none
module grid_stencil_pde_step #(
    parameter int MAX_WIDTH = 256
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // cell_value[31:0], cell_velocity[63:32]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // out_row[7:0], out_col[15:8], new_value[47:16],
                                   // new_velocity[79:48]
    output logic        m_tlast    // frame_done
);
    import gsp_pkg::*;

    cfg_t  cfg_reg;
    cell_t push_data, pop_data;
    logic  push, pop, q_full, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode        <= MODE_HEAT;
            cfg_reg.grid_width  <= RST_GRID_WIDTH;
            cfg_reg.grid_height <= RST_GRID_HEIGHT;
            cfg_reg.gain_rows   <= RST_GAIN_ROWS;
            cfg_reg.gain_cols   <= RST_GAIN_COLS;
            cfg_reg.damping     <= RST_DAMPING;
            cfg_reg.step_dt     <= RST_STEP_DT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:        cfg_reg.mode        <= cfg_data[0];
                REG_GRID_WIDTH:  cfg_reg.grid_width  <= cfg_data[8:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height <= cfg_data[8:0];
                REG_GAIN_ROWS:   cfg_reg.gain_rows   <= cfg_data[30:0];
                REG_GAIN_COLS:   cfg_reg.gain_cols   <= cfg_data[30:0];
                REG_DAMPING:     cfg_reg.damping     <= cfg_data;
                REG_STEP_DT:     cfg_reg.step_dt     <= cfg_data;
                default: ;
            endcase
        end
    end

    gsp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .q_full   (q_full),
        .s_tdata  (s_tdata),
        .s_tready (s_tready),
        .push     (push),
        .entry    (push_data)
    );

    gsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    gsp_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

### rtl/core/gsp_queue.sv
`default_nettype none
module gsp_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  gsp_pkg::cell_t      push_data,
    input  wire                 pop,
    output gsp_pkg::cell_t      pop_data,
    output logic                full,
    output logic                empty
);
    import gsp_pkg::*;

    cell_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### rtl/core/gsp_front.sv
`default_nettype none
module gsp_front #(
    parameter int MAX_WIDTH = 256
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  gsp_pkg::cfg_t       cfg,
    input  wire                 s_tvalid,
    input  wire                 q_full,
    input  wire  [63:0]         s_tdata,
    output logic                s_tready,
    output logic                push,
    output gsp_pkg::cell_t      entry
);
    import gsp_pkg::*;

    localparam int DW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;

    logic [7:0]    row_reg, col_reg;
    logic [DW-1:0] gw, w, col_ext, c_ext;
    logic [8:0]    h;
    logic [7:0]    c, e;
    logic          last_col, last_row;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        gw = DW'(cfg.grid_width);
        if (gw < DW'(3)) begin
            w = DW'(3);
        end else if (gw > DW'(MAX_WIDTH)) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = gw;
        end
        if (cfg.grid_height < 9'd3) begin
            h = 9'd3;
        end else if (cfg.grid_height > 9'd256) begin
            h = 9'd256;
        end else begin
            h = cfg.grid_height;
        end
        col_ext  = DW'(col_reg);
        last_col = col_ext >= (w - DW'(1));
        last_row = {1'b0, row_reg} >= (h - 9'd1);
        c_ext    = (col_ext >= DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH - 1) : col_ext;
        c        = c_ext[7:0];
        e        = row_reg - 8'd1;

        entry.u        = s_tdata[31:0];
        entry.v        = s_tdata[63:32];
        entry.emit_row = e;
        entry.row      = row_reg;
        entry.col      = c;
        entry.emit     = (row_reg != 8'd0);
        entry.border   = (e == 8'd0) || ({1'b0, e} >= (h - 9'd1)) || (c == 8'd0) ||
                         last_col || ((c_ext + DW'(1)) >= DW'(MAX_WIDTH));
        entry.last_row = last_row;
        entry.last_col = last_col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= 8'd0;
            col_reg <= 8'd0;
        end else if (push) begin
            if (last_col) begin
                col_reg <= 8'd0;
                row_reg <= last_row ? 8'd0 : row_reg + 8'd1;
            end else begin
                col_reg <= col_reg + 8'd1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/gsp_back.sv
`default_nettype none
module gsp_back #(
    parameter int MAX_WIDTH = 256
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  gsp_pkg::cfg_t       cfg,
    input  wire                 q_empty,
    input  gsp_pkg::cell_t      q_data,
    output logic                q_pop,
    input  wire                 m_tready,
    output logic                m_tvalid,
    output logic [79:0]         m_tdata,
    output logic                m_tlast
);
    import gsp_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_RD   = 12'b000000000010,
        ST_RD2  = 12'b000000000100,
        ST_DIFF = 12'b000000001000,
        ST_MAG  = 12'b000000010000,
        ST_P0   = 12'b000000100000,
        ST_P1   = 12'b000001000000,
        ST_ACC  = 12'b000010000000,
        ST_USE  = 12'b000100000000,
        ST_OUT1 = 12'b001000000000,
        ST_OUT2 = 12'b010000000000,
        ST_WR   = 12'b100000000000
    } state_t;

    typedef enum logic [1:0] {
        OP_DR   = 2'd0,
        OP_DC   = 2'd1,
        OP_DAMP = 2'd2,
        OP_DT   = 2'd3
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    cell_t  cur_reg;

    logic signed [31:0] older_mem [MAX_WIDTH];
    logic signed [31:0] mid_mem   [MAX_WIDTH];
    logic signed [31:0] vel_mem   [MAX_WIDTH];
    logic signed [31:0] mid_q, old_q, vel_q;

    logic [AW+8:0]  addr_ext, addr_p1_ext;
    logic [AW-1:0]  addr, rd_addr;

    logic signed [31:0] ctr_reg, vel_reg, up_reg, prev_ctr_reg, nu_reg, nv_reg;
    logic signed [39:0] dr_reg, dc_reg, t1_reg, vs_reg, mres_reg;
    logic [33:0]        mag_reg;
    logic               neg_reg;
    logic [31:0]        b_reg;
    logic [49:0]        plo_reg, phi_reg;

    logic signed [39:0] op_a, op_abs, term, ctr40, vel40;
    logic [31:0]        op_b;
    logic [65:0]        psum, pshift;
    logic [39:0]        mag_r;
    logic               out_free, out_load;
    logic [79:0]        out_data;
    logic               out_last;

    assign addr_ext    = {{(AW+1){1'b0}}, cur_reg.col};
    assign addr_p1_ext = addr_ext + {{(AW+8){1'b0}}, 1'b1};
    assign addr        = addr_ext[AW-1:0];
    assign rd_addr     = (state_reg == ST_RD2) ? addr_p1_ext[AW-1:0] : addr;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) begin
            older_mem[addr] <= ctr_reg;
            mid_mem[addr]   <= cur_reg.u;
            vel_mem[addr]   <= cur_reg.v;
        end
        mid_q <= mid_mem[rd_addr];
        old_q <= older_mem[addr];
        vel_q <= vel_mem[addr];
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_free = !m_tvalid || m_tready;
    assign ctr40    = 40'(ctr_reg);
    assign vel40    = 40'(vel_reg);
    assign term     = t1_reg + mres_reg;

    always_comb begin
        unique case (op_reg)
            OP_DR:   begin op_a = dr_reg; op_b = {1'b0, cfg.gain_rows}; end
            OP_DC:   begin op_a = dc_reg; op_b = {1'b0, cfg.gain_cols}; end
            OP_DAMP: begin op_a = vs_reg; op_b = cfg.damping;          end
            OP_DT:   begin op_a = 40'(nv_reg); op_b = cfg.step_dt;     end
            default: begin op_a = dr_reg; op_b = {1'b0, cfg.gain_rows}; end
        endcase
        op_abs = op_a[39] ? -op_a : op_a;
        psum   = {phi_reg, 16'd0} + {16'd0, plo_reg};
        unique case (op_reg)
            OP_DT:   pshift = psum >> 32;
            OP_DAMP: pshift = psum >> 31;
            default: pshift = psum >> 30;
        endcase
        mag_r = {3'd0, pshift[36:0]};
    end

    // Emit the cell above first, then the arriving cell when it sits on the last row.
    always_comb begin
        out_load = 1'b0;
        out_data = {nv_reg, nu_reg, cur_reg.col, cur_reg.emit_row};
        out_last = 1'b0;
        if (state_reg == ST_OUT1 && cur_reg.emit && out_free) begin
            out_load = 1'b1;
        end else if (state_reg == ST_OUT2 && cur_reg.last_row && out_free) begin
            out_load = 1'b1;
            out_data = {cur_reg.v, cur_reg.u, cur_reg.col, cur_reg.row};
            out_last = cur_reg.last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata <= out_data;
            m_tlast <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DR;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (!q_empty) begin
                    state_reg <= ST_RD;
                end
                ST_RD:   state_reg <= ST_RD2;
                ST_RD2:  state_reg <= (cur_reg.emit && !cur_reg.border) ? ST_DIFF : ST_OUT1;
                ST_DIFF: begin
                    op_reg    <= OP_DR;
                    state_reg <= ST_MAG;
                end
                ST_MAG:  state_reg <= ST_P0;
                ST_P0:   state_reg <= ST_P1;
                ST_P1:   state_reg <= ST_ACC;
                ST_ACC:  state_reg <= ST_USE;
                ST_USE: begin
                    unique case (op_reg)
                        OP_DR: begin
                            op_reg    <= OP_DC;
                            state_reg <= ST_MAG;
                        end
                        OP_DC: begin
                            if (cfg.mode == MODE_HEAT) begin
                                state_reg <= ST_OUT1;
                            end else begin
                                op_reg    <= OP_DAMP;
                                state_reg <= ST_MAG;
                            end
                        end
                        OP_DAMP: begin
                            op_reg    <= OP_DT;
                            state_reg <= ST_MAG;
                        end
                        OP_DT:   state_reg <= ST_OUT1;
                        default: state_reg <= ST_OUT1;
                    endcase
                end
                ST_OUT1: if (!cur_reg.emit || out_free) begin
                    state_reg <= ST_OUT2;
                end
                ST_OUT2: if (!cur_reg.last_row || out_free) begin
                    state_reg <= ST_WR;
                end
                ST_WR:   state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        unique case (state_reg)
            ST_RD2: begin
                ctr_reg <= mid_q;
                vel_reg <= vel_q;
                up_reg  <= old_q;
                nu_reg  <= mid_q;
                nv_reg  <= vel_q;
            end
            ST_DIFF: begin
                // Left neighbor is the center of the previous cell in this row.
                dr_reg <= 40'(up_reg) + 40'(cur_reg.u) - (ctr40 <<< 1);
                dc_reg <= 40'(prev_ctr_reg) + 40'(mid_q) - (ctr40 <<< 1);
            end
            ST_MAG: begin
                neg_reg <= op_a[39];
                mag_reg <= op_abs[33:0];
                b_reg   <= op_b;
            end
            ST_P0:  plo_reg <= mag_reg * b_reg[15:0];
            ST_P1:  phi_reg <= mag_reg * b_reg[31:16];
            ST_ACC: mres_reg <= neg_reg ? -$signed(mag_r) : $signed(mag_r);
            ST_USE: begin
                unique case (op_reg)
                    OP_DR: t1_reg <= mres_reg;
                    OP_DC: begin
                        if (cfg.mode == MODE_HEAT) begin
                            nu_reg <= sat32(ctr40 + term);
                        end else begin
                            vs_reg <= 40'(sat32(vel40 + term));
                        end
                    end
                    OP_DAMP: nv_reg <= sat32(mres_reg);
                    OP_DT:   nu_reg <= sat32(ctr40 + mres_reg);
                    default: t1_reg <= mres_reg;
                endcase
            end
            ST_WR:   prev_ctr_reg <= ctr_reg;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/gsp_checker.sv
`default_nettype none
module gsp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [79:0] m_tdata,
    input wire        m_tlast
);
    // Output channel is empty right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // End of pass is never on the first rows or first columns.
    a_done_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] >= 8'd2)
        else $error("frame end on an early row");

    a_done_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[15:8] >= 8'd2)
        else $error("frame end on an early column");
endmodule

bind grid_stencil_pde_step gsp_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

### sim/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] value;
        logic [31:0] velocity;
        logic        done;
    } cell_out_t;

    // Directed row: typed = 1 means the expected cells are written out here.
    typedef struct {
        logic [31:0] value;
        logic [31:0] velocity;
        bit          typed;
        int          n_out;
        cell_out_t   out0;
        cell_out_t   out1;
    } stim_row_t;

    typedef enum int {
        PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH
    } pace_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         m_tlast;

    grid_stencil_pde_step i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // stencil state mirrored for prediction
    logic        st_mode;
    logic [8:0]  st_width, st_height;
    logic [30:0] st_gain_rows, st_gain_cols;
    logic [31:0] st_damping, st_step_dt;
    longint      prev_row_u [256];
    longint      cur_row_u [256];
    longint      cur_row_v [256];
    int          row_pos, col_pos;

    cell_out_t   pending_cells [$];
    pace_t       pace = PACE_FULL;
    bit          hold_req = 1'b0;
    int          fail_count = 0;
    int          cells_sent = 0;
    int          cells_checked = 0;
    int          idle_cycles = 0;
    int          phase_count = 0;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // exact product, truncated toward zero on the magnitude
    function automatic longint scale_trunc(longint a, logic [31:0] b, int sh);
        logic [127:0] mag;
        logic [127:0] prod;
        bit neg;
        neg = a < 0;
        mag = neg ? 128'(-a) : 128'(a);
        prod = (mag * {96'b0, b}) >> sh;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic int clamp_dim(logic [8:0] d);
        if (d < 3) return 3;
        if (d > 256) return 256;
        return int'(d);
    endfunction

    function automatic cell_out_t mk_cell(int r, int c, longint u, longint v, bit done);
        cell_out_t o;
        o.row = r[7:0];
        o.col = c[7:0];
        o.value = u[31:0];
        o.velocity = v[31:0];
        o.done = done;
        return o;
    endfunction

    // advance the stencil by one arriving cell; returns the cells it releases
    function automatic int stencil_advance(logic [31:0] u_raw, logic [31:0] v_raw,
                                           ref cell_out_t outs [2]);
        int w, h, r, c, e, n;
        longint u_in, v_in, ctr, vel, nu, nv, up, left, right, dr, dc, term, vs;
        bit last_col, last_row, border;
        w = clamp_dim(st_width);
        h = clamp_dim(st_height);
        r = row_pos;
        c = col_pos;
        n = 0;
        u_in = longint'(signed'(u_raw));
        v_in = longint'(signed'(v_raw));
        last_col = c >= w - 1;
        last_row = r >= h - 1;
        if (c >= 256) c = 255;
        if (r >= 1) begin
            e = r - 1;
            ctr = cur_row_u[c];
            vel = cur_row_v[c];
            nu = ctr;
            nv = vel;
            border = e == 0 || e >= h - 1 || c == 0 || last_col || c + 1 >= 256;
            if (!border) begin
                up = prev_row_u[c];
                left = prev_row_u[c-1];
                right = cur_row_u[c+1];
                dr = up + u_in - 2 * ctr;
                dc = left + right - 2 * ctr;
                term = scale_trunc(dr, {1'b0, st_gain_rows}, 30)
                     + scale_trunc(dc, {1'b0, st_gain_cols}, 30);
                if (st_mode == MODE_HEAT) begin
                    nu = clip32(ctr + term);
                end else begin
                    vs = clip32(vel + term);
                    nv = clip32(scale_trunc(vs, st_damping, 31));
                    nu = clip32(ctr + scale_trunc(nv, st_step_dt, 32));
                end
            end
            outs[n] = mk_cell(e, c, nu, nv, 1'b0);
            n++;
        end
        if (last_row) begin
            outs[n] = mk_cell(r, c, u_in, v_in, last_col);
            n++;
        end
        prev_row_u[c] = cur_row_u[c];
        cur_row_u[c] = u_in;
        cur_row_v[c] = v_in;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : (r + 1) & 8'hFF;
        end else begin
            col_pos = (c + 1) & 8'hFF;
        end
        return n;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_MODE:        st_mode = data[0];
            REG_GRID_WIDTH:  st_width = data[8:0];
            REG_GRID_HEIGHT: st_height = data[8:0];
            REG_GAIN_ROWS:   st_gain_rows = data[30:0];
            REG_GAIN_COLS:   st_gain_cols = data[30:0];
            REG_DAMPING:     st_damping = data;
            REG_STEP_DT:     st_step_dt = data;
            default: ;
        endcase
    endtask

    task automatic load_setup(logic m, logic [8:0] w, logic [8:0] h, logic [30:0] gr,
                              logic [30:0] gc, logic [31:0] damp, logic [31:0] dt);
        write_reg(REG_MODE, {31'b0, m});
        write_reg(REG_GRID_WIDTH, {23'b0, w});
        write_reg(REG_GRID_HEIGHT, {23'b0, h});
        write_reg(REG_GAIN_ROWS, {1'b0, gr});
        write_reg(REG_GAIN_COLS, {1'b0, gc});
        write_reg(REG_DAMPING, damp);
        write_reg(REG_STEP_DT, dt);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // offer one cell until it is taken, then predict what it releases
    task automatic send_cell(logic [31:0] u, logic [31:0] v, bit typed = 0, int n_typed = 0,
                             cell_out_t t0 = '{default: '0}, cell_out_t t1 = '{default: '0});
        cell_out_t outs [2];
        int n;
        bit taken;
        bit gap;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            gap = (pace == PACE_SRC_IDLE) ? ($urandom_range(99) < 86) :
                  (pace == PACE_BOTH) ? ($urandom_range(99) < 29) : 1'b0;
            if (gap) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= {v, u};
                @(posedge aclk);
                taken = s_tready;
            end
        end
        n = stencil_advance(u, v, outs);
        cells_sent++;
        if (typed) begin
            if (n != n_typed) begin
                $error("released count: expected %0d, actual %0d", n_typed, n);
                fail_count++;
            end
            if (n_typed > 0) pending_cells.push_back(t0);
            if (n_typed > 1) pending_cells.push_back(t1);
        end else begin
            for (int k = 0; k < n; k++) pending_cells.push_back(outs[k]);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_cell_value();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(2 ** 20)) - (2 ** 19)) <<< $urandom_range(8);
    endfunction

    task automatic send_grids(int grids);
        int total;
        total = grids * clamp_dim(st_width) * clamp_dim(st_height);
        for (int k = 0; k < total; k++) send_cell(rand_cell_value(), rand_cell_value());
    endtask

    // sink side: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        int hold_left;
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (pace)
                PACE_SINK_STALL: m_tready <= $urandom_range(99) >= 86;
                PACE_BOTH:       m_tready <= $urandom_range(99) >= 29;
                default:         m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        cell_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            cells_checked++;
            if (pending_cells.size() == 0) begin
                $error("unexpected result row=%0d col=%0d", m_tdata[7:0], m_tdata[15:8]);
                fail_count++;
            end else begin
                want = pending_cells.pop_front();
                if (m_tdata[7:0] !== want.row) begin
                    $error("out_row: expected %0d, actual %0d", want.row, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.col) begin
                    $error("out_col: expected %0d, actual %0d", want.col, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[47:16] !== want.value) begin
                    $error("new_value: expected %h, actual %h", want.value, m_tdata[47:16]);
                    fail_count++;
                end
                if (m_tdata[79:48] !== want.velocity) begin
                    $error("new_velocity: expected %h, actual %h", want.velocity,
                           m_tdata[79:48]);
                    fail_count++;
                end
                if (m_tlast !== want.done) begin
                    $error("frame_done: expected %0d, actual %0d", want.done, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t plan [$];
        int random_cells;
        logic [8:0] w, h;
        st_mode = MODE_HEAT;
        st_width = RST_GRID_WIDTH;
        st_height = RST_GRID_HEIGHT;
        st_gain_rows = RST_GAIN_ROWS;
        st_gain_cols = RST_GAIN_COLS;
        st_damping = RST_DAMPING;
        st_step_dt = RST_STEP_DT;
        row_pos = 0;
        col_pos = 0;
        foreach (prev_row_u[k]) begin
            prev_row_u[k] = 0;
            cur_row_u[k] = 0;
            cur_row_v[k] = 0;
        end

        // 3x3 heat grid of extremes; results are typed but for the cell that releases the interior, which is predicted
        plan = '{
            '{32'h7FFFFFFF, 32'h80000000, 1, 0, '{default: '0}, '{default: '0}},
            '{32'h80000000, 32'h7FFFFFFF, 1, 0, '{default: '0}, '{default: '0}},
            '{32'h00000000, 32'h00000001, 1, 0, '{default: '0}, '{default: '0}},
            '{32'h00000001, 32'h00000002, 1, 1,
              '{8'd0, 8'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0}, '{default: '0}},
            '{32'h7FFFFFFF, 32'h00000000, 1, 1,
              '{8'd0, 8'd1, 32'h80000000, 32'h7FFFFFFF, 1'b0}, '{default: '0}},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1,
              '{8'd0, 8'd2, 32'h00000000, 32'h00000001, 1'b0}, '{default: '0}},
            '{32'h80000000, 32'h00000000, 1, 2,
              '{8'd1, 8'd0, 32'h00000001, 32'h00000002, 1'b0},
              '{8'd2, 8'd0, 32'h80000000, 32'h00000000, 1'b0}},
            '{32'h00000000, 32'h00000000, 0, 0, '{default: '0}, '{default: '0}},
            '{32'h00000005, 32'h00000006, 1, 2,
              '{8'd1, 8'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0},
              '{8'd2, 8'd2, 32'h00000005, 32'h00000006, 1'b1}}
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        load_setup(MODE_HEAT, 9'd3, 9'd3, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000,
                   32'hFFFFFFFF);
        foreach (plan[k]) begin
            send_cell(plan[k].value, plan[k].velocity, plan[k].typed, plan[k].n_out,
                      plan[k].out0, plan[k].out1);
        end
        // same extremes through the wave path, all predicted
        settle();
        load_setup(MODE_WAVE, 9'd3, 9'd3, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000,
                   32'hFFFFFFFF);
        foreach (plan[k]) send_cell(plan[k].value, plan[k].velocity);
        settle();

        // geometry: clamped-low, a wide row, a tall grid
        pace = PACE_SRC_IDLE;
        load_setup(MODE_WAVE, 9'd0, 9'd2, 31'd0, 31'd0, 32'd0, 32'd0);
        send_grids(2);
        settle();
        pace = PACE_SINK_STALL;
        load_setup(MODE_HEAT, 9'd64, 9'd3, 31'h7FFFFFFF, 31'd0, 32'h80000000, 32'd0);
        send_grids(1);
        settle();
        pace = PACE_BOTH;
        load_setup(MODE_WAVE, 9'd3, 9'd48, 31'd0, 31'h7FFFFFFF, 32'h80000000,
                   32'hFFFFFFFF);
        send_grids(1);
        settle();
        phase_count = 5;

        random_cells = 0;
        while (random_cells < 250) begin
            pace = pace_t'(phase_count % 4);
            w = 9'($urandom_range(3, 14));
            h = 9'($urandom_range(3, 8));
            load_setup(1'($urandom_range(1)),
                       w, h,
                       ($urandom_range(2) == 0) ? 31'($urandom) : 31'($urandom_range(2 ** 28)),
                       ($urandom_range(2) == 0) ? 31'($urandom) : 31'($urandom_range(2 ** 28)),
                       ($urandom_range(3) == 0) ? 32'h80000000 : 32'($urandom),
                       $urandom);
            if (phase_count == 6) begin
                pace = PACE_FULL;
                hold_req = 1'b1;
            end
            random_cells += 2 * clamp_dim(st_width) * clamp_dim(st_height);
            send_grids(2);
            settle();
            phase_count++;
        end

        $display("covered %0d cells in, %0d results out, over %0d setup phases", cells_sent,
                 cells_checked, phase_count);
        $display("heat and wave modes, clamped and extreme geometry, stalls and a long hold-off");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
rtl/core/gsp_pkg.sv
rtl/core/gsp_queue.sv
rtl/core/gsp_front.sv
rtl/core/gsp_back.sv
rtl/core/grid_stencil_pde_step.sv
rtl/core/gsp_checker.sv
sim/tb.sv
